// ===== rtl/core/rgl_pkg.sv =====
// ----------------------------------------------------------------------------
// rgl_pkg
// Shared constants, types and helper functions for the RPM gradient LED bar.
// ----------------------------------------------------------------------------
`default_nettype none

package rgl_pkg;

    // Default geometry and scaling of the strip.
    localparam int STRIP_LEDS_DEF     = 16;
    localparam int REDLINE_LEDS_DEF   = 2;
    localparam int FULL_SCALE_RPM_DEF = 8000;

    // Fixed field widths.
    localparam int RPM_W      = 16;
    localparam int PIX_IDX_W  = 4;
    localparam int GRB_W      = 24;
    localparam int BRIGHT_W   = 9;
    localparam int CHAN_W     = 8;

    // Brightness register reset value and full-scale value.
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 9'd26;
    localparam logic [BRIGHT_W-1:0] BRIGHT_FULL  = 9'd256;

    // Largest channel value.
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Palette in red, green, blue order: green, blue, yellow, red.
    localparam logic [CHAN_W-1:0] PALETTE_RGB [4][3] = '{
        '{8'd0,   8'd255, 8'd0},
        '{8'd0,   8'd0,   8'd255},
        '{8'd255, 8'd255, 8'd0},
        '{8'd255, 8'd0,   8'd0}
    };

    // One result item as it leaves the back part.
    typedef struct packed {
        logic [PIX_IDX_W-1:0] pixel_index;
        logic [GRB_W-1:0]     pixel_colour;
        logic                 last_pixel;
    } t_pixel;

    // Channel k (0 red, 1 green, 2 blue) of palette entry s.
    function automatic int pal_chan(input logic [1:0] s, input logic [1:0] k);
        int c;
        c = 0;
        case (k)
            2'd0:    c = int'(PALETTE_RGB[s][0]);
            2'd1:    c = int'(PALETTE_RGB[s][1]);
            2'd2:    c = int'(PALETTE_RGB[s][2]);
            default: c = 0;
        endcase
        return c;
    endfunction

    // Number of LEDs that form the bar below the redline.
    function automatic int bar_leds(input int strip, input int redline);
        return (redline >= strip) ? 0 : strip - redline;
    endfunction

    // Width of rpm multiplied by the bar length.
    function automatic int rpm_bar_width(input int bar);
        return RPM_W + $clog2(bar + 1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rgl_if.sv =====
// ----------------------------------------------------------------------------
// rgl_if
// Valid/ready channel interfaces for speed items and pixel items.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgl_rpm_if
    import rgl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RPM_W-1:0] rpm;

    modport source (output valid, output rpm, input ready);
    modport sink   (input valid, input rpm, output ready);
endinterface

interface rgl_pix_if
    import rgl_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [GRB_W-1:0]     pixel_colour;
    logic                 last_pixel;

    modport source (output valid, output pixel_index, output pixel_colour, output last_pixel,
                    input ready);
    modport sink   (input valid, input pixel_index, input pixel_colour, input last_pixel,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rgl_front.sv =====
// ----------------------------------------------------------------------------
// rgl_front
// Accepts speed items and scales each by the bar length for the lit test.
// ----------------------------------------------------------------------------
`default_nettype none

module rgl_front
    import rgl_pkg::*;
#(
    parameter int STRIP_LEDS   = STRIP_LEDS_DEF,
    parameter int REDLINE_LEDS = REDLINE_LEDS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_rpm_valid,
    output logic                o_rpm_ready,
    input  wire  [RPM_W-1:0]    i_rpm,
    output logic                o_frame_valid,
    input  wire                 i_frame_ready,
    output logic [rpm_bar_width(bar_leds(STRIP_LEDS, REDLINE_LEDS))-1:0] o_rpm_bar
);

    localparam int BAR  = bar_leds(STRIP_LEDS, REDLINE_LEDS);
    localparam int RB_W = rpm_bar_width(BAR);

    logic            r_valid;
    logic [RB_W-1:0] r_rpm_bar;
    logic [RB_W-1:0] n_rpm_bar;

    // The holding register frees up as soon as the queue takes its item.
    assign o_rpm_ready   = !r_valid || i_frame_ready;
    assign o_frame_valid = r_valid;
    assign o_rpm_bar     = r_rpm_bar;

    // rpm times bar length; LED i is lit when (i+1)*full_scale <= this product.
    assign n_rpm_bar = RB_W'(i_rpm) * RB_W'(BAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rpm_ready) begin
            r_valid <= i_rpm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rpm_ready && i_rpm_valid) begin
            r_rpm_bar <= n_rpm_bar;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rgl_queue.sv =====
// ----------------------------------------------------------------------------
// rgl_queue
// Small register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module rgl_queue
    import rgl_pkg::*;
#(
    parameter int DATA_W = 16,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Pointer and fill count bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage is written only where the write pointer stands.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rgl_back.sv =====
// ----------------------------------------------------------------------------
// rgl_back
// Walks the strip one LED per cycle while the output is not stalled, and
// scales each colour through a pipelined multiply and reciprocal divide.
// ----------------------------------------------------------------------------
`default_nettype none

module rgl_back
    import rgl_pkg::*;
#(
    parameter int STRIP_LEDS     = STRIP_LEDS_DEF,
    parameter int REDLINE_LEDS   = REDLINE_LEDS_DEF,
    parameter int FULL_SCALE_RPM = FULL_SCALE_RPM_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [BRIGHT_W-1:0] i_bright,
    input  wire                 i_frame_valid,
    output logic                o_frame_ready,
    input  wire  [rpm_bar_width(bar_leds(STRIP_LEDS, REDLINE_LEDS))-1:0] i_rpm_bar,
    output logic                o_pix_valid,
    input  wire                 i_pix_ready,
    output t_pixel              o_pix
);

    localparam int BAR     = bar_leds(STRIP_LEDS, REDLINE_LEDS);
    localparam int RB_W    = rpm_bar_width(BAR);
    localparam int BAR_DEN = (BAR > 1) ? BAR - 1 : 1;
    localparam int IDX_W   = $clog2(STRIP_LEDS);
    localparam int TH_W    = $clog2(STRIP_LEDS * FULL_SCALE_RPM + 1);
    localparam int CMP_W   = (TH_W > RB_W) ? TH_W : RB_W;
    localparam int SEG     = FULL_SCALE_RPM / 4;
    localparam int SEG_W   = $clog2(SEG + 1);
    localparam int NUM_W   = $clog2(255 * SEG + 1);
    localparam int X_W     = NUM_W + BRIGHT_W;
    localparam int Z_W     = X_W - 8;
    localparam longint unsigned RECIP = (64'd1 << 32) / SEG;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int P_W     = Z_W + RECIP_W;
    localparam int Q_W     = CHAN_W + 1;
    localparam int M_W     = Q_W + SEG_W;
    localparam int FIX_W   = ((Z_W > M_W) ? Z_W : M_W) + 1;

    // Per-LED colour numerators at full brightness, worked out at elaboration.
    logic [NUM_W-1:0] lut_num [STRIP_LEDS][3];

    for (genvar g = 0; g < STRIP_LEDS; g++) begin : g_lut
        localparam int V   = (BAR > 1) ? (g * (FULL_SCALE_RPM - 1)) / BAR_DEN : 0;
        localparam int S   = V / SEG;
        localparam int F   = V - S * SEG;
        localparam int SA  = (S >= 3) ? 3 : S;
        localparam int SB  = (S >= 3) ? 3 : S + 1;
        localparam bit RED = (g >= BAR) || (S >= 3);
        for (genvar k = 0; k < 3; k++) begin : g_chan
            localparam int N = RED ? ((k == 0) ? 255 * SEG : 0)
                                   : pal_chan(2'(SA), 2'(k)) * (SEG - F)
                                     + pal_chan(2'(SB), 2'(k)) * F;
            assign lut_num[g][k] = NUM_W'(N);
        end
    end

    // Pipeline advances whenever the output register is free or being taken.
    logic r_v4;
    logic adv;
    assign adv = !r_v4 || i_pix_ready;

    // Sequencer state for the frame being walked.
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic [TH_W-1:0]  r_thresh;
    logic [RB_W-1:0]  r_rpm_bar;
    logic             issue_last;
    logic             is_bar;
    logic             lit;
    logic [NUM_W-1:0] num_sel [3];

    assign issue_last    = r_busy && (r_idx == IDX_W'(STRIP_LEDS - 1));
    assign o_frame_ready = adv && (!r_busy || issue_last);

    // Load a new frame as the previous one issues its final LED.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (adv) begin
            if (o_frame_ready && i_frame_valid) begin
                r_busy <= 1'b1;
            end else if (issue_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (o_frame_ready && i_frame_valid) begin
                r_idx     <= '0;
                r_thresh  <= TH_W'(FULL_SCALE_RPM);
                r_rpm_bar <= i_rpm_bar;
            end else if (r_busy) begin
                r_idx    <= r_idx + 1'b1;
                r_thresh <= r_thresh + TH_W'(FULL_SCALE_RPM);
            end
        end
    end

    // Classify the LED: redline, lit bar or dark bar.
    assign is_bar = ({1'b0, r_idx} < (IDX_W + 1)'(BAR));
    assign lit    = (CMP_W'(r_thresh) <= CMP_W'(r_rpm_bar));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num_sel[k] = (is_bar && !lit) ? '0 : lut_num[r_idx][k];
        end
    end

    // Stage registers.
    logic                 r_v0, r_v1, r_v2, r_v3;
    logic [PIX_IDX_W-1:0] r_i0, r_i1, r_i2, r_i3;
    logic                 r_l0, r_l1, r_l2, r_l3;
    logic [NUM_W-1:0]     r_n0 [3];
    logic [X_W-1:0]       r_x1 [3];
    logic [Z_W-1:0]       r_z2 [3];
    logic [P_W-1:0]       r_p2 [3];
    logic [Z_W-1:0]       r_z3 [3];
    logic [Q_W-1:0]       r_q3 [3];
    logic [M_W-1:0]       r_m3 [3];
    t_pixel               r_pix;
    logic [BRIGHT_W-1:0]  b_eff;
    logic [Q_W-1:0]       q_fix [3];
    logic [CHAN_W-1:0]    chan  [3];

    assign b_eff = (i_bright > BRIGHT_FULL) ? BRIGHT_FULL : i_bright;

    // Valid bits move with the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v0 <= r_busy;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Final correction of the reciprocal quotient and clamp to a byte.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            q_fix[k] = (FIX_W'(r_z3[k]) >= FIX_W'(r_m3[k]) + FIX_W'(SEG))
                       ? r_q3[k] + 1'b1 : r_q3[k];
            chan[k]  = (q_fix[k] > Q_W'(CHAN_MAX)) ? CHAN_MAX : q_fix[k][CHAN_W-1:0];
        end
    end

    // Datapath: brightness multiply, shift and reciprocal multiply, remainder check.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_i0 <= PIX_IDX_W'(r_idx);
            r_l0 <= issue_last;
            r_i1 <= r_i0;
            r_l1 <= r_l0;
            r_i2 <= r_i1;
            r_l2 <= r_l1;
            r_i3 <= r_i2;
            r_l3 <= r_l2;
            for (int k = 0; k < 3; k++) begin
                r_n0[k] <= num_sel[k];
                r_x1[k] <= X_W'(r_n0[k]) * X_W'(b_eff);
                r_z2[k] <= r_x1[k][X_W-1:8];
                r_p2[k] <= P_W'(r_x1[k][X_W-1:8]) * P_W'(RECIP);
                r_z3[k] <= r_z2[k];
                r_q3[k] <= r_p2[k][32 +: Q_W];
                r_m3[k] <= M_W'(r_p2[k][32 +: Q_W]) * M_W'(SEG);
            end
            r_pix.pixel_index  <= r_i3;
            r_pix.last_pixel   <= r_l3;
            r_pix.pixel_colour <= {chan[1], chan[0], chan[2]};
        end
    end

    assign o_pix_valid = r_v4;
    assign o_pix       = r_pix;

endmodule

`default_nettype wire

// ===== rtl/core/rpm_gradient_led_bar_core.sv =====
// ----------------------------------------------------------------------------
// rpm_gradient_led_bar_core
// Turns one engine speed item into a frame of GRB pixel items for an LED bar.
// ----------------------------------------------------------------------------
// Each accepted speed item produces STRIP_LEDS pixel items (16 by default),
// one per cycle while the output side keeps up, as the back part's sequencer
// walks one LED per cycle. A speed item passes the input register, the
// queue, the sequencer and the datapath stages before its first pixel shows.
// A two-item queue sits between the input register and the sequencer, and
// the next frame starts in the cycle after the previous frame's last LED is
// issued. The user writes brightness through i_cfg_we and i_cfg_wdata only
// while the block is idle (not enforced); values above 256 act as 256.
`default_nettype none

module rpm_gradient_led_bar_core
    import rgl_pkg::*;
#(
    parameter int STRIP_LEDS     = STRIP_LEDS_DEF,
    parameter int REDLINE_LEDS   = REDLINE_LEDS_DEF,
    parameter int FULL_SCALE_RPM = FULL_SCALE_RPM_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [BRIGHT_W-1:0] i_cfg_wdata,
    rgl_rpm_if.sink            i_rpm_chan,
    rgl_pix_if.source          o_pix_chan
);

    localparam int BAR  = bar_leds(STRIP_LEDS, REDLINE_LEDS);
    localparam int RB_W = rpm_bar_width(BAR);

    logic [BRIGHT_W-1:0] r_bright;
    logic                fr_valid;
    logic                fr_ready;
    logic [RB_W-1:0]     fr_rpm_bar;
    logic                q_valid;
    logic                q_ready;
    logic [RB_W-1:0]     q_rpm_bar;
    logic                pix_valid;
    t_pixel              pix;

    // Brightness register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= BRIGHT_RESET;
        end else if (i_cfg_we) begin
            r_bright <= i_cfg_wdata;
        end
    end

    // Front part: takes speed items.
    rgl_front #(
        .STRIP_LEDS   (STRIP_LEDS),
        .REDLINE_LEDS (REDLINE_LEDS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rpm_valid   (i_rpm_chan.valid),
        .o_rpm_ready   (i_rpm_chan.ready),
        .i_rpm         (i_rpm_chan.rpm),
        .o_frame_valid (fr_valid),
        .i_frame_ready (fr_ready),
        .o_rpm_bar     (fr_rpm_bar)
    );

    // Queue between the two parts.
    rgl_queue #(
        .DATA_W (RB_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_data  (fr_rpm_bar),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_rpm_bar)
    );

    // Back part: walks the strip and produces pixel items.
    rgl_back #(
        .STRIP_LEDS     (STRIP_LEDS),
        .REDLINE_LEDS   (REDLINE_LEDS),
        .FULL_SCALE_RPM (FULL_SCALE_RPM)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bright      (r_bright),
        .i_frame_valid (q_valid),
        .o_frame_ready (q_ready),
        .i_rpm_bar     (q_rpm_bar),
        .o_pix_valid   (pix_valid),
        .i_pix_ready   (o_pix_chan.ready),
        .o_pix         (pix)
    );

    assign o_pix_chan.valid        = pix_valid;
    assign o_pix_chan.pixel_index  = pix.pixel_index;
    assign o_pix_chan.pixel_colour = pix.pixel_colour;
    assign o_pix_chan.last_pixel   = pix.last_pixel;

endmodule

`default_nettype wire

// ===== rtl/core/rgl_checker.sv =====
// ----------------------------------------------------------------------------
// rgl_checker
// Port-level checks of frame order and output behaviour of the LED bar core.
// ----------------------------------------------------------------------------
`default_nettype none

module rgl_checker
    import rgl_pkg::*;
#(
    parameter int STRIP_LEDS = STRIP_LEDS_DEF
) (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 i_in_ready,
    input wire                 i_out_valid,
    input wire                 i_out_ready,
    input wire [PIX_IDX_W-1:0] i_out_idx,
    input wire [GRB_W-1:0]     i_out_grb,
    input wire                 i_out_last
);

    localparam int IDX_W = $clog2(STRIP_LEDS);

    logic             r_exp_last;
    logic [IDX_W-1:0] r_exp_idx;
    logic [3:0]       r_pending;
    logic             in_take;
    logic             out_take;
    logic             out_done;

    assign in_take  = i_in_valid && i_in_ready;
    assign out_take = i_out_valid && i_out_ready;
    assign out_done = out_take && i_out_last;
    assign r_exp_last = (r_exp_idx == IDX_W'(STRIP_LEDS - 1));

    // Expected position within the frame and frames still owed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
            r_pending <= '0;
        end else begin
            if (out_take) begin
                r_exp_idx <= r_exp_last ? '0 : r_exp_idx + 1'b1;
            end
            if (in_take && !out_done) begin
                r_pending <= r_pending + 1'b1;
            end else if (out_done && !in_take) begin
                r_pending <= r_pending - 1'b1;
            end
        end
    end

    // A pixel item only appears for a speed item still owed a frame.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != '0))
        else $error("pixel item without an outstanding speed item");

    // Pixels come out in strip order with the end of frame marked.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_idx == PIX_IDX_W'(r_exp_idx)) && (i_out_last == r_exp_last))
        else $error("pixel index or end of frame out of sequence");

    // Output is quiet in the first cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("pixel item offered straight after reset");

    // A stalled pixel item holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_idx)
            && $stable(i_out_grb) && $stable(i_out_last))
        else $error("stalled pixel item changed");

endmodule

bind rpm_gradient_led_bar_core rgl_checker #(
    .STRIP_LEDS (STRIP_LEDS)
) u_rgl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_rpm_chan.valid),
    .i_in_ready  (i_rpm_chan.ready),
    .i_out_valid (o_pix_chan.valid),
    .i_out_ready (o_pix_chan.ready),
    .i_out_idx   (o_pix_chan.pixel_index),
    .i_out_grb   (o_pix_chan.pixel_colour),
    .i_out_last  (o_pix_chan.last_pixel)
);

`default_nettype wire
